@@ src/ps2mct_pkg.sv @@
// ps2mct_pkg: shared constants and types for the ps2 mouse cursor tracker
// used by every module of the block, no dependencies of its own
`timescale 1ns / 1ps

package ps2mct_pkg;

  // coordinate and register widths
  localparam int COORD_BITS    = 12;
  localparam int CURSOR_MARGIN = 5;
  localparam int CFG_W         = 13;
  localparam int CFG_IDX_W     = 1;
  localparam int DELTA_W       = 10;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'd1;

  // register reset values
  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RESET  = CFG_W'(800);
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RESET = CFG_W'(600);
  localparam logic [COORD_BITS-1:0] POS_X_RESET = COORD_BITS'(400);
  localparam logic [COORD_BITS-1:0] POS_Y_RESET = COORD_BITS'(300);

  // header byte bit positions
  localparam int HDR_ALIGN_BIT  = 3;
  localparam int HDR_X_SIGN_BIT = 4;
  localparam int HDR_Y_SIGN_BIT = 5;

  // place in the three byte packet
  typedef enum logic [2:0] {
    BYTE_HDR = 3'b001,
    BYTE_X   = 3'b010,
    BYTE_Y   = 3'b100
  } byte_state_t;

  // one controller byte as held in the input register
  typedef struct packed {
    logic       aux_flag;
    logic [7:0] data_byte;
  } byte_item_t;

endpackage

@@ src/ps2mct_axis.sv @@
// ps2mct_axis: add a signed delta to one cursor axis and clamp it to the screen
// depends on ps2mct_pkg
`timescale 1ns / 1ps

module ps2mct_axis (
  input  logic [ps2mct_pkg::COORD_BITS-1:0] pos,
  input  logic signed [ps2mct_pkg::DELTA_W-1:0] delta,
  input  logic [ps2mct_pkg::CFG_W-1:0]      screen_size,
  output logic [ps2mct_pkg::COORD_BITS-1:0] pos_new
);
  import ps2mct_pkg::*;

  localparam int SUM_W  = COORD_BITS + 2;
  localparam int CALC_W = (SUM_W > CFG_W + 1) ? SUM_W : CFG_W + 1;
  localparam logic signed [CALC_W-1:0] COORD_MAX = CALC_W'((1 << COORD_BITS) - 1);

  logic signed [CALC_W-1:0] sum;
  logic signed [CALC_W-1:0] bound_raw;
  logic signed [CALC_W-1:0] bound;
  logic signed [CALC_W-1:0] clamped;

  // upper bound is size minus margin, saturated to the coordinate range
  always_comb begin
    bound_raw = signed'(CALC_W'(screen_size)) - signed'(CALC_W'(CURSOR_MARGIN));
    if (bound_raw < 0) begin
      bound = '0;
    end else if (bound_raw > COORD_MAX) begin
      bound = COORD_MAX;
    end else begin
      bound = bound_raw;
    end
  end

  // add, clamp low first, then high
  always_comb begin
    sum = signed'(CALC_W'(pos)) + CALC_W'(delta);
    clamped = sum;
    if (clamped < 0) begin
      clamped = '0;
    end
    if (clamped > bound) begin
      clamped = bound;
    end
    pos_new = clamped[COORD_BITS-1:0];
  end

endmodule

@@ src/ps2mct_tracker.sv @@
// ps2mct_tracker: packet gathering, cursor state and the result register
// depends on ps2mct_pkg and ps2mct_axis
`timescale 1ns / 1ps

module ps2mct_tracker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  ps2mct_pkg::byte_item_t            item,
  input  logic [ps2mct_pkg::CFG_W-1:0]      screen_width,
  input  logic [ps2mct_pkg::CFG_W-1:0]      screen_height,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [ps2mct_pkg::COORD_BITS-1:0] out_cursor_x,
  output logic [ps2mct_pkg::COORD_BITS-1:0] out_cursor_y,
  output logic                              out_moved,
  output logic                              out_dropped
);
  import ps2mct_pkg::*;

  byte_state_t            state_r, state_nxt;
  logic [7:0]             hdr_r, hdr_nxt;
  logic [7:0]             xb_r, xb_nxt;
  logic [COORD_BITS-1:0]  pos_x_r, pos_x_nxt;
  logic [COORD_BITS-1:0]  pos_y_r, pos_y_nxt;
  logic                   out_valid_r;
  logic [COORD_BITS-1:0]  out_x_r, out_y_r;
  logic                   out_moved_r, out_dropped_r;
  logic                   moved, dropped;
  logic signed [DELTA_W-1:0] dx, dy;
  logic [8:0]             dy9;
  logic [COORD_BITS-1:0]  new_x, new_y;

  // 9-bit deltas from header sign bits, y negated for screen orientation
  always_comb begin
    dx  = signed'({hdr_r[HDR_X_SIGN_BIT], hdr_r[HDR_X_SIGN_BIT], xb_r});
    dy9 = {hdr_r[HDR_Y_SIGN_BIT], item.data_byte};
    dy  = -signed'({dy9[8], dy9});
  end

  ps2mct_axis u_axis_x (
    .pos         (pos_x_r),
    .delta       (dx),
    .screen_size (screen_width),
    .pos_new     (new_x)
  );

  ps2mct_axis u_axis_y (
    .pos         (pos_y_r),
    .delta       (dy),
    .screen_size (screen_height),
    .pos_new     (new_y)
  );

  // packet gathering and position update
  always_comb begin
    state_nxt = state_r;
    hdr_nxt   = hdr_r;
    xb_nxt    = xb_r;
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    moved     = 1'b0;
    dropped   = 1'b0;
    if (step && item.aux_flag) begin
      case (state_r)
        BYTE_HDR: begin
          hdr_nxt   = item.data_byte;
          state_nxt = BYTE_X;
        end
        BYTE_X: begin
          xb_nxt    = item.data_byte;
          state_nxt = BYTE_Y;
        end
        default: begin
          state_nxt = BYTE_HDR;
          if (!hdr_r[HDR_ALIGN_BIT]) begin
            dropped = 1'b1;
          end else begin
            moved     = 1'b1;
            pos_x_nxt = new_x;
            pos_y_nxt = new_y;
          end
        end
      endcase
    end
  end

  // packet and cursor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BYTE_HDR;
      hdr_r   <= '0;
      xb_r    <= '0;
      pos_x_r <= POS_X_RESET;
      pos_y_r <= POS_Y_RESET;
    end else begin
      state_r <= state_nxt;
      hdr_r   <= hdr_nxt;
      xb_r    <= xb_nxt;
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (step) begin
      out_x_r       <= pos_x_nxt;
      out_y_r       <= pos_y_nxt;
      out_moved_r   <= moved;
      out_dropped_r <= dropped;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_cursor_x = out_x_r;
  assign out_cursor_y = out_y_r;
  assign out_moved    = out_moved_r;
  assign out_dropped  = out_dropped_r;

`ifndef ASSERT_OFF
  // a result never claims both a move and a drop
  a_moved_xor_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_moved_r && out_dropped_r))
    else $error("result flagged both moved and dropped");

  // the third flagged byte always closes the packet
  a_packet_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.aux_flag && state_r == BYTE_Y) |=> state_r == BYTE_HDR)
    else $error("packet did not close on third byte");

  // the cursor only moves on a processed byte
  a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> ($stable(pos_x_r) && $stable(pos_y_r)))
    else $error("cursor moved without a byte");

  // a processed byte always lands in the result register
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("processed byte produced no result");

  // the result shows the cursor state it left behind
  a_result_matches: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> (out_x_r == pos_x_r && out_y_r == pos_y_r))
    else $error("result differs from cursor state");
`endif

endmodule

@@ src/ps2mct_pkg_unused_guard.sv @@
// ps2mct_cfg: configuration registers for the screen size bounds
// depends on ps2mct_pkg
`timescale 1ns / 1ps

module ps2mct_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ps2mct_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ps2mct_pkg::CFG_W-1:0]        cfg_wdata,
  output logic [ps2mct_pkg::CFG_W-1:0]        screen_width,
  output logic [ps2mct_pkg::CFG_W-1:0]        screen_height
);
  import ps2mct_pkg::*;

  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] height_r;

  // register writes by index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SCREEN_WIDTH_RESET;
      height_r <= SCREEN_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  width_r  <= cfg_wdata;
        CFG_SCREEN_HEIGHT: height_r <= cfg_wdata;
        default: begin
          width_r  <= width_r;
          height_r <= height_r;
        end
      endcase
    end
  end

  assign screen_width  = width_r;
  assign screen_height = height_r;

endmodule

@@ src/ps2_mouse_cursor_tracker_core.sv @@
// ps2_mouse_cursor_tracker_core: top level of the ps2 mouse cursor tracker
// depends on ps2mct_pkg, ps2mct_cfg and ps2mct_tracker
`timescale 1ns / 1ps

// The block takes one controller byte per transfer and returns one result per byte:
// the cursor position after that byte and whether it completed a moved or a dropped
// packet. Bytes without the aux flag leave the state alone. It sustains one byte per
// clock cycle while the result register is free or draining; a byte's result is
// offered once it passes from the input register into the result register, which
// happens when that register is free or draining. The rate is set by the loop
// through the packet state and the position add-and-clamp feeding the cursor
// registers. Screen size registers may be written only while no byte is in flight.
module ps2_mouse_cursor_tracker_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ps2mct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ps2mct_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_aux_flag,
  input  logic [7:0]                        in_data_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ps2mct_pkg::COORD_BITS-1:0] out_cursor_x,
  output logic [ps2mct_pkg::COORD_BITS-1:0] out_cursor_y,
  output logic                              out_moved,
  output logic                              out_dropped
);
  import ps2mct_pkg::*;

  logic             in_valid_r;
  byte_item_t       in_item_r;
  logic             step;
  logic [CFG_W-1:0] screen_width;
  logic [CFG_W-1:0] screen_height;

  ps2mct_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .screen_width  (screen_width),
    .screen_height (screen_height)
  );

  // a held byte moves on when the result register is free or draining
  assign step     = in_valid_r && (!out_valid || out_ready);
  assign in_ready = !in_valid_r || step;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_item_r.aux_flag  <= in_aux_flag;
      in_item_r.data_byte <= in_data_byte;
    end
  end

  ps2mct_tracker u_tracker (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .item          (in_item_r),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_cursor_x  (out_cursor_x),
    .out_cursor_y  (out_cursor_y),
    .out_moved     (out_moved),
    .out_dropped   (out_dropped)
  );

endmodule
